@@ hdl/jrdz_pkg.sv @@
package jrdz_pkg;

  // Full-scale deflection and register reset value.
  localparam logic [14:0] FULL_SCALE = 15'd32767;
  localparam logic [14:0] DZ_RESET   = 15'd7849;

  // Quotient bits produced by the divider, one per stage.
  localparam int unsigned QW = 16;

  // Sideband that travels with a sample through the front end and the root.
  typedef struct packed {
    logic        valid;
    logic        in_dz;
    logic        neg_x;
    logic        neg_y;
    logic [15:0] mag_x;
    logic [15:0] mag_y;
  } side_t;

  // Control bits that travel with a sample through the divider.
  typedef struct packed {
    logic valid;
    logic in_dz;
    logic neg_x;
    logic neg_y;
  } ctl_t;

endpackage

@@ hdl/jrdz_sqrt.sv @@
// Pipelined integer square root, one result bit per stage.
module jrdz_sqrt #(
  parameter int unsigned F = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic [32+2*F-1:0]     v_in,
  input  jrdz_pkg::side_t       sb_in,
  output logic [16+F-1:0]       root_out,
  output jrdz_pkg::side_t       sb_out
);

  localparam int unsigned VW  = 32 + 2 * F;
  localparam int unsigned RW  = 16 + F;
  localparam int unsigned RMW = RW + 3;

  logic [RMW-1:0]  rem_r  [RW];
  logic [RW-1:0]   root_r [RW];
  logic [VW-1:0]   v_r    [RW];
  jrdz_pkg::side_t sb_r   [RW];

  for (genvar g = 0; g < RW; g++) begin : g_stage
    logic [RMW-1:0]  rem_prev;
    logic [RW-1:0]   root_prev;
    logic [VW-1:0]   v_prev;
    jrdz_pkg::side_t sb_prev;
    logic [RMW-1:0]  cat;
    logic [RMW-1:0]  trial;
    logic            take;

    if (g == 0) begin : g_first
      assign rem_prev  = '0;
      assign root_prev = '0;
      assign v_prev    = v_in;
      assign sb_prev   = sb_in;
    end else begin : g_next
      assign rem_prev  = rem_r[g-1];
      assign root_prev = root_r[g-1];
      assign v_prev    = v_r[g-1];
      assign sb_prev   = sb_r[g-1];
    end

    // Bring down the next two radicand bits and try the next root bit.
    always_comb begin
      cat   = {rem_prev[RMW-3:0], v_prev[VW-1 -: 2]};
      trial = {1'b0, root_prev, 2'b01};
      take  = (cat >= trial);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sb_r[g] <= '0;
      end else if (en) begin
        sb_r[g] <= sb_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g]  <= take ? (cat - trial) : cat;
        root_r[g] <= {root_prev[RW-2:0], take};
        v_r[g]    <= v_prev << 2;
      end
    end
  end

  assign root_out = root_r[RW-1];
  assign sb_out   = sb_r[RW-1];

endmodule

@@ hdl/jrdz_div.sv @@
// Pipelined restoring divider for both axes over a shared divisor,
// one quotient bit per stage.
module jrdz_div #(
  parameter int unsigned F = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic [46+F-1:0]        num_x,
  input  logic [46+F-1:0]        num_y,
  input  logic [31+F-1:0]        den_in,
  input  jrdz_pkg::ctl_t         ctl_in,
  output logic [jrdz_pkg::QW-1:0] q_x,
  output logic [jrdz_pkg::QW-1:0] q_y,
  output jrdz_pkg::ctl_t         ctl_out
);

  localparam int unsigned QW   = jrdz_pkg::QW;
  localparam int unsigned DENW = 31 + F;
  localparam int unsigned W    = DENW + QW;

  logic [W-1:0]    rx_r  [QW];
  logic [W-1:0]    ry_r  [QW];
  logic [QW-1:0]   qx_r  [QW];
  logic [QW-1:0]   qy_r  [QW];
  logic [DENW-1:0] den_r [QW];
  jrdz_pkg::ctl_t  ctl_r [QW];

  for (genvar g = 0; g < QW; g++) begin : g_stage
    logic [W-1:0]    rx_prev;
    logic [W-1:0]    ry_prev;
    logic [QW-1:0]   qx_prev;
    logic [QW-1:0]   qy_prev;
    logic [DENW-1:0] den_prev;
    jrdz_pkg::ctl_t  ctl_prev;
    logic [W-1:0]    dsh;
    logic            ge_x;
    logic            ge_y;

    if (g == 0) begin : g_first
      assign rx_prev  = W'(num_x);
      assign ry_prev  = W'(num_y);
      assign qx_prev  = '0;
      assign qy_prev  = '0;
      assign den_prev = den_in;
      assign ctl_prev = ctl_in;
    end else begin : g_next
      assign rx_prev  = rx_r[g-1];
      assign ry_prev  = ry_r[g-1];
      assign qx_prev  = qx_r[g-1];
      assign qy_prev  = qy_r[g-1];
      assign den_prev = den_r[g-1];
      assign ctl_prev = ctl_r[g-1];
    end

    // Compare each remainder with the divisor at this bit's weight.
    always_comb begin
      dsh  = W'(den_prev) << (QW - 1 - g);
      ge_x = (rx_prev >= dsh);
      ge_y = (ry_prev >= dsh);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[g] <= '0;
      end else if (en) begin
        ctl_r[g] <= ctl_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rx_r[g]  <= ge_x ? (rx_prev - dsh) : rx_prev;
        ry_r[g]  <= ge_y ? (ry_prev - dsh) : ry_prev;
        qx_r[g]  <= {qx_prev[QW-2:0], ge_x};
        qy_r[g]  <= {qy_prev[QW-2:0], ge_y};
        den_r[g] <= den_prev;
      end
    end
  end

  assign q_x     = qx_r[QW-1];
  assign q_y     = qy_r[QW-1];
  assign ctl_out = ctl_r[QW-1];

endmodule

@@ hdl/joystick_radial_dead_zone.sv @@
// Channel  | Direction | Handshake               | Payload
// in_      | input     | in_valid / in_stall     | in_stick_x, in_stick_y
// out_     | output    | out_valid / out_stall   | out_x, out_y, out_inside_dead_zone
// cfg_     | input     | cfg_wr_en               | cfg_wr_data (dead-zone radius)
//
// One sample is accepted per cycle while in_stall is low; each sample passes
// through the front end, the one-bit-per-stage root and divider, and the output register.
// Reset is synchronous and active low; it empties the pipeline and loads a
// dead-zone radius of 7849. A stall on a waiting result freezes the whole pipeline,
// and in_stall follows out_stall while a result is waiting.
module joystick_radial_dead_zone #(
  parameter int unsigned ROOT_FRACTION_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_stick_x,
  input  logic signed [15:0] in_stick_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  output logic               out_inside_dead_zone,
  input  logic               cfg_wr_en,
  input  logic [14:0]        cfg_wr_data
);

  localparam int unsigned F    = ROOT_FRACTION_BITS;
  localparam int unsigned VW   = 32 + 2 * F;
  localparam int unsigned RW   = 16 + F;
  localparam int unsigned SPW  = 15 + F;
  localparam int unsigned PMW  = 31 + F;
  localparam int unsigned NUMW = 46 + F;
  localparam int unsigned DENW = 31 + F;
  localparam int unsigned QW   = jrdz_pkg::QW;
  localparam logic [RW-1:0] CAP = RW'(jrdz_pkg::FULL_SCALE) << F;
  localparam logic [29:0] DSQ_RESET =
    30'(int'(jrdz_pkg::DZ_RESET) * int'(jrdz_pkg::DZ_RESET));

  logic en;

  // Configuration: the radius and its square.
  logic [14:0] dz_r;
  logic [29:0] dsq_r;
  logic [14:0] dspan;
  logic [RW-1:0] dzf;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dz_r  <= jrdz_pkg::DZ_RESET;
      dsq_r <= DSQ_RESET;
    end else begin
      if (cfg_wr_en && (cfg_wr_data != jrdz_pkg::FULL_SCALE)) begin
        dz_r <= cfg_wr_data;
      end
      dsq_r <= dz_r * dz_r;
    end
  end

  assign dspan = jrdz_pkg::FULL_SCALE - dz_r;
  assign dzf   = RW'(dz_r) << F;

  // The whole pipeline advances unless a finished result is held back.
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Stage 1: axis magnitudes and signs.
  jrdz_pkg::side_t s1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
    end else if (en) begin
      s1_r.valid  <= in_valid;
      s1_r.in_dz  <= 1'b0;
      s1_r.neg_x  <= in_stick_x[15];
      s1_r.neg_y  <= in_stick_y[15];
      s1_r.mag_x  <= in_stick_x[15] ? 16'(~in_stick_x + 16'd1) : in_stick_x;
      s1_r.mag_y  <= in_stick_y[15] ? 16'(~in_stick_y + 16'd1) : in_stick_y;
    end
  end

  // Stage 2: squares of both axes.
  jrdz_pkg::side_t s2_r;
  logic [31:0] sqx_r;
  logic [31:0] sqy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r <= '0;
    end else if (en) begin
      s2_r <= s1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx_r <= s1_r.mag_x * s1_r.mag_x;
      sqy_r <= s1_r.mag_y * s1_r.mag_y;
    end
  end

  // Stage 3: squared radius and the exact dead-zone test.
  jrdz_pkg::side_t s3_r;
  jrdz_pkg::side_t s3_nxt;
  logic [31:0] sum_r;
  logic [31:0] sum_nxt;

  always_comb begin
    sum_nxt      = sqx_r + sqy_r;
    s3_nxt       = s2_r;
    s3_nxt.in_dz = (sum_nxt <= 32'(dsq_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_r <= '0;
    end else if (en) begin
      s3_r <= s3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= sum_nxt;
    end
  end

  // Radius with fraction bits.
  logic [RW-1:0]   root;
  jrdz_pkg::side_t sa_in;

  jrdz_sqrt #(.F(F)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .v_in     (VW'(sum_r) << (2 * F)),
    .sb_in    (s3_r),
    .root_out (root),
    .sb_out   (sa_in)
  );

  // Stage A: clamp the radius and measure past the dead-zone edge.
  jrdz_pkg::side_t sa_r;
  logic [RW-1:0]   ra_r;
  logic [SPW-1:0]  span_r;
  logic [RW-1:0]   rc;

  assign rc = (root > CAP) ? CAP : root;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_r <= '0;
    end else if (en) begin
      sa_r <= sa_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ra_r   <= root;
      span_r <= (rc > dzf) ? SPW'(rc - dzf) : '0;
    end
  end

  // Stage B: axis times span, and the divisor.
  jrdz_pkg::ctl_t sb_ctl_r;
  logic [PMW-1:0]  pmx_r;
  logic [PMW-1:0]  pmy_r;
  logic [DENW-1:0] denb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_ctl_r <= '0;
    end else if (en) begin
      sb_ctl_r <= '{valid: sa_r.valid, in_dz: sa_r.in_dz,
                    neg_x: sa_r.neg_x, neg_y: sa_r.neg_y};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pmx_r  <= sa_r.mag_x * span_r;
      pmy_r  <= sa_r.mag_y * span_r;
      denb_r <= ra_r * dspan;
    end
  end

  // Stage C: times full scale by shift and subtract; a zero divisor becomes one.
  jrdz_pkg::ctl_t  sc_ctl_r;
  logic [NUMW-1:0] numx_r;
  logic [NUMW-1:0] numy_r;
  logic [DENW-1:0] denc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_ctl_r <= '0;
    end else if (en) begin
      sc_ctl_r <= sb_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      numx_r <= (NUMW'(pmx_r) << 15) - NUMW'(pmx_r);
      numy_r <= (NUMW'(pmy_r) << 15) - NUMW'(pmy_r);
      denc_r <= (denb_r == '0) ? DENW'(1) : denb_r;
    end
  end

  // Quotients for both axes.
  logic [QW-1:0]  qx;
  logic [QW-1:0]  qy;
  jrdz_pkg::ctl_t qctl;

  jrdz_div #(.F(F)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .num_x   (numx_r),
    .num_y   (numy_r),
    .den_in  (denc_r),
    .ctl_in  (sc_ctl_r),
    .q_x     (qx),
    .q_y     (qy),
    .ctl_out (qctl)
  );

  // Output register: saturate, restore the sign, zero inside the dead zone.
  logic [15:0] satx;
  logic [15:0] saty;
  logic [15:0] resx;
  logic [15:0] resy;

  always_comb begin
    satx = (qx > QW'(jrdz_pkg::FULL_SCALE)) ? 16'(jrdz_pkg::FULL_SCALE) : 16'(qx);
    saty = (qy > QW'(jrdz_pkg::FULL_SCALE)) ? 16'(jrdz_pkg::FULL_SCALE) : 16'(qy);
    resx = qctl.neg_x ? 16'(~satx + 16'd1) : satx;
    resy = qctl.neg_y ? 16'(~saty + 16'd1) : saty;
    if (qctl.in_dz) begin
      resx = '0;
      resy = '0;
    end
  end

  logic valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= qctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x                <= resx;
      out_y                <= resy;
      out_inside_dead_zone <= qctl.in_dz;
    end
  end

  assign out_valid = valid_r;

endmodule

@@ hdl/jrdz_chk.sv @@
// Port-level checks for the dead-zone block.
module jrdz_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] out_x,
  input logic signed [15:0] out_y,
  input logic               out_inside_dead_zone
);

  // A sample inside the dead zone reports no deflection.
  a_inside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_inside_dead_zone |-> out_x == 16'sd0 && out_y == 16'sd0)
    else $error("dead-zone result with nonzero deflection");

  // Magnitudes never exceed full scale.
  a_no_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_x != -16'sd32768 && out_y != -16'sd32768)
    else $error("result beyond full scale");

  // The input is held back exactly while a result waits.
  a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not match output backpressure");

  // A result that is not transferred stays put.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(out_y))
    else $error("stalled result changed");

endmodule

bind joystick_radial_dead_zone jrdz_chk u_jrdz_chk (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_stall             (in_stall),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_x                (out_x),
  .out_y                (out_y),
  .out_inside_dead_zone (out_inside_dead_zone)
);
